// ===== hw/rtl/gpq_pkg.sv =====
// Shared constants for the gamma pixel quantizer.
package gpq_pkg;

  // Width of one accumulated colour sum on the bus.
  localparam int SUM_BITS  = 32;
  // Fraction bits of the sums, and so the width of an unsaturated average.
  localparam int FRAC_BITS = 16;
  // Width of the square root of a FRAC_BITS-wide average, and of a colour channel.
  localparam int ROOT_BITS = FRAC_BITS / 2;
  // Width of the sample count register.
  localparam int DIV_BITS  = 16;
  // Remainder width of the root recurrence: at most twice the partial root.
  localparam int SREM_BITS = ROOT_BITS + 1;

  // Full-scale channel code.
  localparam logic [ROOT_BITS-1:0] CHAN_MAX = '1;

  // Input register, one stage per quotient bit, one per root bit, output register.
  localparam int LATENCY = 1 + FRAC_BITS + ROOT_BITS + 1;

endpackage

// ===== hw/rtl/gpq_channel.sv =====
// One colour channel: pipelined divide by the sample count, square root and saturation.
module gpq_channel
  import gpq_pkg::*;
#(
  parameter int SUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [SUM_BITS-1:0]  sum,
  input  logic [DIV_BITS-1:0]  div,
  output logic [ROOT_BITS-1:0] chan
);

  // Only the low SUM_WIDTH bits of a sum take part.
  localparam logic [SUM_BITS-1:0] SUM_MASK = (SUM_WIDTH >= SUM_BITS) ? '1 :
    SUM_BITS'((64'(1) << SUM_WIDTH) - 64'(1));

  logic [SUM_BITS-1:0] masked;

  // Divider stages: index k holds the state after k quotient bits.
  logic [DIV_BITS-1:0]  drem [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] dlow [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] dquo [FRAC_BITS+1];
  logic                 dsat [FRAC_BITS+1];

  // Root stages: index j holds the state after j root bits.
  logic [FRAC_BITS-1:0] srad  [1:ROOT_BITS];
  logic [SREM_BITS-1:0] srem  [1:ROOT_BITS];
  logic [ROOT_BITS-1:0] sroot [1:ROOT_BITS];
  logic                 ssat  [1:ROOT_BITS];

  assign masked = sum & SUM_MASK;

  // Input stage. An average of one or more saturates; otherwise the upper half
  // of the sum is already below the divisor and seeds the partial remainder.
  always_ff @(posedge clk) begin
    if (en) begin
      dsat[0] <= masked >= {div, {FRAC_BITS{1'b0}}};
      drem[0] <= masked[SUM_BITS-1:FRAC_BITS];
      dlow[0] <= masked[FRAC_BITS-1:0];
      dquo[0] <= '0;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_div
    logic [DIV_BITS:0] trial;
    logic              fits;

    assign trial = {drem[k-1], dlow[k-1][FRAC_BITS-1]};
    assign fits  = trial >= {1'b0, div};

    always_ff @(posedge clk) begin
      if (en) begin
        drem[k] <= fits ? DIV_BITS'(trial - {1'b0, div}) : trial[DIV_BITS-1:0];
        dlow[k] <= {dlow[k-1][FRAC_BITS-2:0], 1'b0};
        dquo[k] <= {dquo[k-1][FRAC_BITS-2:0], fits};
        dsat[k] <= dsat[k-1];
      end
    end
  end

  // Digit-by-digit square root of the quotient, one root bit per stage.
  for (genvar j = 1; j <= ROOT_BITS; j++) begin : g_root
    logic [FRAC_BITS-1:0] rad_prev;
    logic [SREM_BITS-1:0] rem_prev;
    logic [ROOT_BITS-1:0] root_prev;
    logic                 sat_prev;
    logic [SREM_BITS+1:0] trial;
    logic [SREM_BITS+1:0] test;
    logic                 fits;

    if (j == 1) begin : g_first
      assign rad_prev  = dquo[FRAC_BITS];
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign sat_prev  = dsat[FRAC_BITS];
    end else begin : g_next
      assign rad_prev  = srad[j-1];
      assign rem_prev  = srem[j-1];
      assign root_prev = sroot[j-1];
      assign sat_prev  = ssat[j-1];
    end

    assign trial = {rem_prev, rad_prev[FRAC_BITS-1 -: 2]};
    assign test  = {1'b0, root_prev, 2'b01};
    assign fits  = trial >= test;

    always_ff @(posedge clk) begin
      if (en) begin
        srad[j]  <= {rad_prev[FRAC_BITS-3:0], 2'b00};
        srem[j]  <= fits ? SREM_BITS'(trial - test) : trial[SREM_BITS-1:0];
        sroot[j] <= {root_prev[ROOT_BITS-2:0], fits};
        ssat[j]  <= sat_prev;
      end
    end
  end

  // Output stage with saturation at full scale.
  always_ff @(posedge clk) begin
    if (en) begin
      chan <= ssat[ROOT_BITS] ? CHAN_MAX : sroot[ROOT_BITS];
    end
  end

endmodule

// ===== hw/rtl/gamma_pixel_quantizer.sv =====
// Top level of the gamma pixel quantizer: stream handshake, sample count and three channels.
//
// Each input beat carries one pixel's red, green and blue sums (unsigned, 16 fraction
// bits). Every channel is divided by the sample count, square-rooted (gamma 2) and
// saturated at 255, and the result beat carries red<<16 | green<<8 | blue. The block
// takes one pixel every clock cycle while the output is not stalled; each result passes
// through one input register, sixteen divider stages that each
// settle one quotient bit, eight root stages that each settle one root bit, and the
// output register. A stall on the output freezes the whole pipeline; while the output
// register is empty or being taken, input is accepted. A sample count of zero is taken
// as one. Write the sample count only while no pixel is in flight.
module gamma_pixel_quantizer
  import gpq_pkg::*;
#(
  parameter int SUM_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [DIV_BITS-1:0]   cfg_wr_data,   // samples
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [3*SUM_BITS-1:0] s_tdata,       // sum_blue, sum_green, sum_red
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [3*ROOT_BITS-1:0] m_tdata       // packed_rgb
);

  logic [DIV_BITS-1:0]  samples;
  logic [LATENCY-1:0]   vld;
  logic                 en;
  logic [ROOT_BITS-1:0] red;
  logic [ROOT_BITS-1:0] green;
  logic [ROOT_BITS-1:0] blue;

  // Sample count register; zero is stored as one so the divider never sees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      samples <= DIV_BITS'(1);
    end else if (cfg_wr_en) begin
      samples <= (cfg_wr_data == '0) ? DIV_BITS'(1) : cfg_wr_data;
    end
  end

  // The pipeline moves whenever the output register is free or being emptied.
  assign en       = !vld[LATENCY-1] || m_tready;
  assign s_tready = en;

  // Valid bits travel alongside the data stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], s_tvalid};
    end
  end

  gpq_channel #(.SUM_WIDTH(SUM_WIDTH)) u_red (
    .clk  (clk),
    .en   (en),
    .sum  (s_tdata[0*SUM_BITS +: SUM_BITS]),
    .div  (samples),
    .chan (red)
  );

  gpq_channel #(.SUM_WIDTH(SUM_WIDTH)) u_green (
    .clk  (clk),
    .en   (en),
    .sum  (s_tdata[1*SUM_BITS +: SUM_BITS]),
    .div  (samples),
    .chan (green)
  );

  gpq_channel #(.SUM_WIDTH(SUM_WIDTH)) u_blue (
    .clk  (clk),
    .en   (en),
    .sum  (s_tdata[2*SUM_BITS +: SUM_BITS]),
    .div  (samples),
    .chan (blue)
  );

  // Result beat.
  assign m_tvalid = vld[LATENCY-1];
  assign m_tdata  = {red, green, blue};

endmodule

// ===== hw/rtl/gpq_checker.sv =====
// Port-level assertions for the gamma pixel quantizer and their bind.
module gpq_checker
  import gpq_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [3*ROOT_BITS-1:0] m_tdata
);

  // A result beat that is not taken stays with the same data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // Input is taken exactly when the output side is free or being emptied.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output state");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat shown straight after reset");

  // A stall holds the whole pipeline, so no input is accepted during it.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(s_tvalid && s_tready))
    else $error("input accepted during an output stall");

endmodule

bind gamma_pixel_quantizer gpq_checker u_gpq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
